/* sv/rbnh_pkg.sv */
// Shared types and constants for the ray/box nearest-hit block.
package rbnh_pkg;

    localparam int MAX_BOXES = 256;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int NUM_W     = 49;
    localparam int T_W       = 50;
    localparam logic signed [31:0] GROUND_DIR_LIMIT = -32'sd7;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_CAST   = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_AX,
        S_DIVA,
        S_DIVB,
        S_AXUPD,
        S_BOXEND,
        S_GND,
        S_GDIV,
        S_MUL,
        S_PADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_box;
        logic ax_zero;
        logic div_lo;
        logic div_hi;
        logic cap_tb;
        logic ax_upd;
        logic next_axis;
        logic box_end;
        logic gnd_start;
        logic gnd_upd;
        logic pt_init;
        logic mul;
        logic pt_add;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic d_zero;
        logic miss;
        logic last_axis;
        logic more_boxes;
        logic div_done;
        logic gnd_ok;
    } t_stat;

endpackage

/* sv/ray_box_nearest_hit.sv */
// Top level of the ray/box nearest-hit caster.
// Usage: drive the request fields and raise start; the request is taken at a
// rising edge where start is high and busy is low. Exactly one result beat
// follows per request, held on the o_ ports for the single cycle o_done is
// high; the receiver cannot stall it and must capture it then.
// Clear, append and no-op requests answer in the cycle after acceptance
// (status set only when an append finds the table full). A cast visits each
// stored box in order: one table read, then for each axis with a nonzero
// direction two serial divisions (lower, then upper slab bound) and a slab
// update (no division for a zero-direction axis), then a step to close the box.
// Downward rays (y direction at or below GROUND_DIR_LIMIT) then get one more
// division for the ground test; the hit point takes a multiply and an add per
// axis, and the result beat follows. The shared divider sets the rate.
// busy stays high until the result beat has been shown.
// Reset (synchronous, active low) empties the table and returns to idle; table
// contents are not cleared, only the entry count.
module ray_box_nearest_hit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic [30:0]        i_max_dist,
    output logic               o_done,
    output logic               o_status,
    output logic               o_hit,
    output logic [30:0]        o_dist_res,
    output logic [7:0]         o_box_index,
    output logic               o_on_ground,
    output logic signed [1:0]  o_normal_x,
    output logic signed [1:0]  o_normal_y,
    output logic signed [1:0]  o_normal_z,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z
);
    rbnh_pkg::t_cmd  cmd;
    rbnh_pkg::t_stat stat;

    rbnh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    rbnh_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_type  (i_req_type),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_a_z       (i_a_z),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_b_z       (i_b_z),
        .i_max_dist  (i_max_dist),
        .o_stat      (stat),
        .o_status    (o_status),
        .o_hit       (o_hit),
        .o_dist_res  (o_dist_res),
        .o_box_index (o_box_index),
        .o_on_ground (o_on_ground),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z)
    );
endmodule

/* sv/rbnh_div.sv */
// Restoring unsigned divider, one quotient bit per cycle, signed result.
module rbnh_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rbnh_pkg::NUM_W-1:0]        i_num_mag,
    input  logic [31:0]                       i_den_mag,
    input  logic                              i_neg,
    output logic                              o_done,
    output logic signed [rbnh_pkg::T_W-1:0]   o_quot
);
    localparam int STEP_W = $clog2(rbnh_pkg::NUM_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [31:0]                r_rem;
    logic [rbnh_pkg::NUM_W-1:0] r_quo;
    logic [31:0]                r_den;
    logic                       r_neg;
    logic [32:0]                shl;
    logic                       ge;
    logic [32:0]                diff;

    assign shl  = {r_rem, r_quo[rbnh_pkg::NUM_W-1]};
    assign ge   = shl >= {1'b0, r_den};
    assign diff = shl - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(rbnh_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num_mag;
            r_den <= i_den_mag;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : shl[31:0];
            r_quo <= {r_quo[rbnh_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |=> r_busy || r_done)
        else $error("divider dropped a division");
endmodule

/* sv/rbnh_ctrl.sv */
// Sequencer for table updates, per-box slab tests, ground test and hit point.
module rbnh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_req_type,
    input  rbnh_pkg::t_stat  i_stat,
    output rbnh_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    rbnh_pkg::t_state r_state;
    rbnh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbnh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            rbnh_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type == rbnh_pkg::REQ_CAST) begin
                        n_state = i_stat.cnt_zero ? rbnh_pkg::S_GND : rbnh_pkg::S_RD;
                    end else begin
                        n_state = rbnh_pkg::S_DONE;
                    end
                end
            end
            rbnh_pkg::S_RD: begin
                o_cmd.load_box = 1'b1;
                n_state = rbnh_pkg::S_AX;
            end
            rbnh_pkg::S_AX: begin
                if (i_stat.miss || i_stat.d_zero) begin
                    o_cmd.ax_zero = !i_stat.miss;
                    if (i_stat.last_axis) begin
                        n_state = rbnh_pkg::S_BOXEND;
                    end else begin
                        o_cmd.next_axis = 1'b1;
                    end
                end else begin
                    o_cmd.div_lo = 1'b1;
                    n_state = rbnh_pkg::S_DIVA;
                end
            end
            rbnh_pkg::S_DIVA: begin
                if (i_stat.div_done) begin
                    o_cmd.div_hi = 1'b1;
                    n_state = rbnh_pkg::S_DIVB;
                end
            end
            rbnh_pkg::S_DIVB: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_tb = 1'b1;
                    n_state = rbnh_pkg::S_AXUPD;
                end
            end
            rbnh_pkg::S_AXUPD: begin
                o_cmd.ax_upd = 1'b1;
                if (i_stat.last_axis) begin
                    n_state = rbnh_pkg::S_BOXEND;
                end else begin
                    o_cmd.next_axis = 1'b1;
                    n_state = rbnh_pkg::S_AX;
                end
            end
            rbnh_pkg::S_BOXEND: begin
                o_cmd.box_end = 1'b1;
                n_state = i_stat.more_boxes ? rbnh_pkg::S_RD : rbnh_pkg::S_GND;
            end
            rbnh_pkg::S_GND: begin
                o_cmd.pt_init = 1'b1;
                if (i_stat.gnd_ok) begin
                    o_cmd.gnd_start = 1'b1;
                    n_state = rbnh_pkg::S_GDIV;
                end else begin
                    n_state = rbnh_pkg::S_MUL;
                end
            end
            rbnh_pkg::S_GDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.gnd_upd = 1'b1;
                    n_state = rbnh_pkg::S_MUL;
                end
            end
            rbnh_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = rbnh_pkg::S_PADD;
            end
            rbnh_pkg::S_PADD: begin
                o_cmd.pt_add = 1'b1;
                if (i_stat.last_axis) begin
                    n_state = rbnh_pkg::S_DONE;
                end else begin
                    o_cmd.next_axis = 1'b1;
                    n_state = rbnh_pkg::S_MUL;
                end
            end
            rbnh_pkg::S_DONE: begin
                n_state = rbnh_pkg::S_IDLE;
            end
            default: begin
                n_state = rbnh_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != rbnh_pkg::S_IDLE;
    assign o_done = r_state == rbnh_pkg::S_DONE;

    a_div_wait_needs_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_lo |=> r_state == rbnh_pkg::S_DIVA)
        else $error("division issued without waiting for it");
endmodule

/* sv/rbnh_dp.sv */
// Box table, slab-test registers, divider feed, hit-point multiplier.
module rbnh_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbnh_pkg::t_cmd      i_cmd,
    input  logic [1:0]          i_req_type,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic [30:0]         i_max_dist,
    output rbnh_pkg::t_stat     o_stat,
    output logic                o_status,
    output logic                o_hit,
    output logic [30:0]         o_dist_res,
    output logic [7:0]          o_box_index,
    output logic                o_on_ground,
    output logic signed [1:0]   o_normal_x,
    output logic signed [1:0]   o_normal_y,
    output logic signed [1:0]   o_normal_z,
    output logic signed [31:0]  o_point_x,
    output logic signed [31:0]  o_point_y,
    output logic signed [31:0]  o_point_z
);
    localparam int TW = rbnh_pkg::T_W;

    logic [2:0][31:0] lo_mem [rbnh_pkg::MAX_BOXES];
    logic [2:0][31:0] hi_mem [rbnh_pkg::MAX_BOXES];

    logic [rbnh_pkg::CNT_W-1:0] r_cnt;
    logic [rbnh_pkg::CNT_W-1:0] r_i;
    logic [1:0]                 r_a;
    logic [2:0][31:0]           r_org, r_dir, r_lo, r_hi, r_pt;
    logic [30:0]                r_near, r_dist;
    logic signed [TW-1:0]       r_t0, r_t1, r_ta, r_tb;
    logic [1:0]                 r_axis, r_haxis;
    logic                       r_sg, r_hsg;
    logic                       r_miss, r_hit, r_ground, r_status;
    logic [7:0]                 r_bidx;
    logic signed [63:0]         r_prod;

    logic [2:0][31:0]           a_vec, b_vec;
    logic signed [31:0]         o_a, d_a, lo_a, hi_a;
    logic signed [31:0]         dv_bound, dv_org, dv_den;
    logic signed [32:0]         dv_diff;
    logic signed [rbnh_pkg::NUM_W-1:0] dv_num;
    logic                       dv_start, dv_done;
    logic signed [TW-1:0]       dv_q;
    logic signed [TW-1:0]       near_x, z_t1, u_ta, u_tb, u_t0, u_t1;
    logic                       u_swap, u_raise;
    logic signed [47:0]         sh_prod;
    logic signed [31:0]         rnd;

    assign a_vec = {i_a_z, i_a_y, i_a_x};
    assign b_vec = {i_b_z, i_b_y, i_b_x};
    assign o_a   = r_org[r_a];
    assign d_a   = r_dir[r_a];
    assign lo_a  = r_lo[r_a];
    assign hi_a  = r_hi[r_a];
    assign near_x = TW'($signed({1'b0, r_near}));

    // divider operand select: slab bound, or the ground plane
    assign dv_start = i_cmd.div_lo | i_cmd.div_hi | i_cmd.gnd_start;
    assign dv_bound = i_cmd.gnd_start ? 32'sd0 : (i_cmd.div_hi ? hi_a : lo_a);
    assign dv_org   = i_cmd.gnd_start ? $signed(r_org[1]) : o_a;
    assign dv_den   = i_cmd.gnd_start ? $signed(r_dir[1]) : d_a;
    assign dv_diff  = 33'(dv_bound) - 33'(dv_org);
    assign dv_num   = {dv_diff, 16'b0};

    rbnh_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (dv_start),
        .i_num_mag (dv_diff[32] ? -dv_num : dv_num),
        .i_den_mag (dv_den[31] ? -dv_den : dv_den),
        .i_neg     (dv_diff[32] ^ dv_den[31]),
        .o_done    (dv_done),
        .o_quot    (dv_q)
    );

    // zero-direction axis
    assign z_t1 = (o_a == hi_a && r_t1 > 0) ? '0 : r_t1;

    // slab update
    assign u_swap  = d_a[31] && (lo_a < hi_a);
    assign u_ta    = u_swap ? r_tb : r_ta;
    assign u_tb    = u_swap ? r_ta : r_tb;
    assign u_raise = u_ta > r_t0;
    assign u_t0    = u_raise ? u_ta : r_t0;
    assign u_t1    = (u_tb < r_t1) ? u_tb : r_t1;

    assign sh_prod = r_prod[63:16];
    assign rnd     = sh_prod[31:0] + {31'b0, r_prod[63] && (r_prod[15:0] != 16'b0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            if (i_req_type == rbnh_pkg::REQ_CLEAR) begin
                r_cnt <= '0;
            end else if (i_req_type == rbnh_pkg::REQ_APPEND &&
                         r_cnt != rbnh_pkg::CNT_W'(rbnh_pkg::MAX_BOXES)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_req_type == rbnh_pkg::REQ_APPEND &&
            r_cnt != rbnh_pkg::CNT_W'(rbnh_pkg::MAX_BOXES)) begin
            for (int k = 0; k < 3; k++) begin
                lo_mem[r_cnt[rbnh_pkg::IDX_W-1:0]][k] <=
                    ($signed(a_vec[k]) < $signed(b_vec[k])) ? a_vec[k] : b_vec[k];
                hi_mem[r_cnt[rbnh_pkg::IDX_W-1:0]][k] <=
                    ($signed(a_vec[k]) < $signed(b_vec[k])) ? b_vec[k] : a_vec[k];
            end
        end
        if (i_cmd.load_box) begin
            r_lo <= lo_mem[r_i[rbnh_pkg::IDX_W-1:0]];
            r_hi <= hi_mem[r_i[rbnh_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_org    <= a_vec;
            r_dir    <= b_vec;
            r_near   <= i_max_dist;
            r_dist   <= '0;
            r_hit    <= 1'b0;
            r_ground <= 1'b0;
            r_bidx   <= '0;
            r_haxis  <= rbnh_pkg::AXIS_NONE;
            r_hsg    <= 1'b0;
            r_i      <= '0;
            r_status <= (i_req_type == rbnh_pkg::REQ_APPEND) &&
                        (r_cnt == rbnh_pkg::CNT_W'(rbnh_pkg::MAX_BOXES));
        end
        if (i_cmd.load_box) begin
            r_t0   <= '0;
            r_t1   <= near_x;
            r_axis <= rbnh_pkg::AXIS_NONE;
            r_sg   <= 1'b0;
            r_miss <= 1'b0;
        end
        if (i_cmd.load_box || i_cmd.pt_init) begin
            r_a <= '0;
        end else if (i_cmd.next_axis) begin
            r_a <= r_a + 1'b1;
        end
        if (i_cmd.ax_zero) begin
            r_t1   <= z_t1;
            r_miss <= (o_a < lo_a) || (o_a > hi_a) || (r_t0 > z_t1);
        end
        if (i_cmd.div_hi) begin
            r_ta <= dv_q;
        end
        if (i_cmd.cap_tb) begin
            r_tb <= dv_q;
        end
        if (i_cmd.ax_upd) begin
            r_t0   <= u_t0;
            r_t1   <= u_t1;
            r_miss <= u_t0 > u_t1;
            if (u_raise) begin
                r_axis <= r_a;
                r_sg   <= u_swap;
            end
        end
        if (i_cmd.box_end) begin
            r_i <= r_i + 1'b1;
            if (!r_miss && r_t0 < near_x) begin
                r_near   <= r_t0[30:0];
                r_dist   <= r_t0[30:0];
                r_hit    <= 1'b1;
                r_ground <= 1'b0;
                r_bidx   <= r_i[7:0];
                r_haxis  <= r_axis;
                r_hsg    <= r_sg;
            end
        end
        if (i_cmd.gnd_upd && dv_q > 0 && dv_q < near_x) begin
            r_near   <= dv_q[30:0];
            r_dist   <= dv_q[30:0];
            r_hit    <= 1'b1;
            r_ground <= 1'b1;
            r_bidx   <= '0;
            r_haxis  <= rbnh_pkg::AXIS_NONE;
        end
        if (i_cmd.mul) begin
            r_prod <= d_a * $signed({1'b0, r_dist});
        end
        if (i_cmd.pt_add) begin
            r_pt[r_a] <= o_a + rnd;
        end
    end

    assign o_stat.cnt_zero   = r_cnt == '0;
    assign o_stat.d_zero     = d_a == '0;
    assign o_stat.miss       = r_miss;
    assign o_stat.last_axis  = r_a == 2'd2;
    assign o_stat.more_boxes = (r_i + 1'b1) < r_cnt;
    assign o_stat.div_done   = dv_done;
    assign o_stat.gnd_ok     = $signed(r_dir[1]) <= rbnh_pkg::GROUND_DIR_LIMIT;

    function automatic logic [1:0] nrm(input logic [1:0] ax, input logic sg,
                                       input logic [1:0] k);
        logic [1:0] v;
        v = 2'b00;
        if (ax == k) begin
            v = sg ? 2'b01 : 2'b11;
        end else if (ax == rbnh_pkg::AXIS_NONE && k == 2'd1) begin
            v = 2'b01;
        end
        return v;
    endfunction

    assign o_status    = r_status;
    assign o_hit       = r_hit;
    assign o_dist_res  = r_hit ? r_dist : '0;
    assign o_box_index = r_hit ? r_bidx : '0;
    assign o_on_ground = r_hit & r_ground;
    assign o_normal_x  = r_hit ? nrm(r_haxis, r_hsg, 2'd0) : '0;
    assign o_normal_y  = r_hit ? nrm(r_haxis, r_hsg, 2'd1) : '0;
    assign o_normal_z  = r_hit ? nrm(r_haxis, r_hsg, 2'd2) : '0;
    assign o_point_x   = r_hit ? r_pt[0] : '0;
    assign o_point_y   = r_hit ? r_pt[1] : '0;
    assign o_point_z   = r_hit ? r_pt[2] : '0;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rbnh_pkg::CNT_W'(rbnh_pkg::MAX_BOXES))
        else $error("box count beyond table depth");
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_box |-> r_i < r_cnt)
        else $error("read of an unfilled table entry");
endmodule

/* bench/tb_ray_box_nearest_hit.sv */
// Testbench for ray_box_nearest_hit: directed and random box tables and ray casts, checked beat by beat.
module tb_ray_box_nearest_hit;

    typedef struct {
        rbnh_pkg::t_req     req;
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic [30:0]        md;
        int                 gap;
        bit                 drain;
    } t_req_item;

    typedef struct packed {
        logic               status;
        logic               hit;
        logic [30:0]        dres;
        logic [7:0]         idx;
        logic               gnd;
        logic signed [1:0]  nx, ny, nz;
        logic signed [31:0] px, py, pz;
    } t_hit_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = '0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic [30:0]        i_max_dist = '0;
    logic               o_done, o_status, o_hit, o_on_ground;
    logic [30:0]        o_dist_res;
    logic [7:0]         o_box_index;
    logic signed [1:0]  o_normal_x, o_normal_y, o_normal_z;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;

    ray_box_nearest_hit i_dut (.*);

    t_req_item pend_q[$];
    t_hit_beat hit_q[$];
    t_req_item cur;
    int        err_cnt = 0;
    int        gap_left = 0;
    bit        armed = 0;
    bit        gen_done = 0;

    // predictor table
    longint tbl_lo[3][rbnh_pkg::MAX_BOXES];
    longint tbl_hi[3][rbnh_pkg::MAX_BOXES];
    int     tbl_cnt = 0;

    // generator shadow of the table
    longint gen_lo[3][rbnh_pkg::MAX_BOXES];
    longint gen_hi[3][rbnh_pkg::MAX_BOXES];
    int     gen_cnt = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic t_hit_beat predict_item(t_req_item it);
        t_hit_beat r;
        longint o[3], d[3], a[3], b[3];
        longint nearest, hdist, t0, t1, ta, tb, tmp, t, p;
        bit hit, gnd, miss;
        int idx, axis, sg, s;
        int nrm[3];
        r = '0;
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
        case (it.req)
            rbnh_pkg::REQ_CLEAR: tbl_cnt = 0;
            rbnh_pkg::REQ_APPEND: begin
                if (tbl_cnt >= rbnh_pkg::MAX_BOXES) r.status = 1'b1;
                else begin
                    for (int k = 0; k < 3; k++) begin
                        tbl_lo[k][tbl_cnt] = a[k] < b[k] ? a[k] : b[k];
                        tbl_hi[k][tbl_cnt] = a[k] < b[k] ? b[k] : a[k];
                    end
                    tbl_cnt++;
                end
            end
            rbnh_pkg::REQ_CAST: begin
                o = a; d = b;
                nearest = longint'({1'b0, it.md});
                hdist = 0; hit = 0; gnd = 0; idx = 0;
                nrm = '{0, 0, 0};
                for (int i = 0; i < tbl_cnt; i++) begin
                    t0 = 0; t1 = nearest; axis = -1; sg = 1; miss = 0;
                    for (int k = 0; k < 3 && !miss; k++) begin
                        if (d[k] == 0) begin
                            if (o[k] < tbl_lo[k][i] || o[k] > tbl_hi[k][i]) miss = 1;
                            else if (o[k] == tbl_hi[k][i] && t1 > 0) t1 = 0;
                        end else begin
                            ta = ((tbl_lo[k][i] - o[k]) * 65536) / d[k];
                            tb = ((tbl_hi[k][i] - o[k]) * 65536) / d[k];
                            s = -1;
                            if (d[k] < 0 && tbl_lo[k][i] < tbl_hi[k][i]) begin
                                tmp = ta; ta = tb; tb = tmp; s = 1;
                            end
                            if (ta > t0) begin t0 = ta; axis = k; sg = s; end
                            if (tb < t1) t1 = tb;
                        end
                        if (t0 > t1) miss = 1;
                    end
                    if (!miss && t0 < nearest) begin
                        nearest = t0; hit = 1; hdist = t0; idx = i;
                        nrm = '{0, 0, 0};
                        if (axis < 0) nrm[1] = 1;
                        else nrm[axis] = sg;
                    end
                end
                if (d[1] <= longint'(rbnh_pkg::GROUND_DIR_LIMIT)) begin
                    t = (-o[1] * 65536) / d[1];
                    if (t > 0 && t < nearest) begin
                        hit = 1; gnd = 1; hdist = t; idx = 0;
                        nrm = '{0, 1, 0};
                    end
                end
                if (hit) begin
                    r.hit  = 1'b1;
                    r.dres = hdist[30:0];
                    r.idx  = idx[7:0];
                    r.gnd  = gnd;
                    r.nx = 2'(nrm[0]); r.ny = 2'(nrm[1]); r.nz = 2'(nrm[2]);
                    p = o[0] + (d[0] * hdist) / 65536; r.px = p[31:0];
                    p = o[1] + (d[1] * hdist) / 65536; r.py = p[31:0];
                    p = o[2] + (d[2] * hdist) / 65536; r.pz = p[31:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit nxt_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            nxt_start = start;
            if (start && !busy) begin
                hit_q = {hit_q, predict_item(cur)};
                nxt_start = 0;
            end
            if (!nxt_start && pend_q.size() > 0) begin
                if (!armed) begin
                    gap_left = pend_q[0].gap;
                    armed = 1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!pend_q[0].drain || hit_q.size() == 0) begin
                    cur = pend_q.pop_front();
                    armed = 0;
                    i_req_type <= cur.req;
                    i_a_x <= cur.ax; i_a_y <= cur.ay; i_a_z <= cur.az;
                    i_b_x <= cur.bx; i_b_y <= cur.by; i_b_z <= cur.bz;
                    i_max_dist <= cur.md;
                    nxt_start = 1;
                end
            end
            start <= nxt_start;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_hit_beat got, want;
        if (i_rst_n && o_done) begin
            got.status = o_status; got.hit = o_hit; got.dres = o_dist_res;
            got.idx = o_box_index; got.gnd = o_on_ground;
            got.nx = o_normal_x; got.ny = o_normal_y; got.nz = o_normal_z;
            got.px = o_point_x; got.py = o_point_y; got.pz = o_point_z;
            if (hit_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result beat: %p", got);
            end else begin
                want = hit_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: status %0d/%0d hit %0d/%0d dist %h/%h idx %0d/%0d",
                                 want.status, got.status, want.hit, got.hit,
                                 want.dres, got.dres, want.idx, got.idx);
                        $display("  gnd %0d/%0d n %0d,%0d,%0d/%0d,%0d,%0d",
                                 want.gnd, got.gnd, want.nx, want.ny, want.nz,
                                 got.nx, got.ny, got.nz);
                        $display("  p %h,%h,%h/%h,%h,%h", want.px, want.py, want.pz,
                                 got.px, got.py, got.pz);
                    end
                end
            end
        end
    end

    function automatic longint rnd_coord(int units);
        return longint'($urandom_range(0, 2 * units * 65536)) - longint'(units) * 65536;
    endfunction

    task automatic add_item(rbnh_pkg::t_req req, longint ax, longint ay, longint az,
                            longint bx, longint by, longint bz, longint md, int gap);
        t_req_item it;
        it.req = req;
        it.ax = ax[31:0]; it.ay = ay[31:0]; it.az = az[31:0];
        it.bx = bx[31:0]; it.by = by[31:0]; it.bz = bz[31:0];
        it.md = md[30:0];
        it.gap = gap;
        it.drain = 0;
        if (req == rbnh_pkg::REQ_CLEAR) gen_cnt = 0;
        if (req == rbnh_pkg::REQ_APPEND && gen_cnt < rbnh_pkg::MAX_BOXES) begin
            gen_lo[0][gen_cnt] = it.ax < it.bx ? it.ax : it.bx;
            gen_hi[0][gen_cnt] = it.ax < it.bx ? it.bx : it.ax;
            gen_lo[1][gen_cnt] = it.ay < it.by ? it.ay : it.by;
            gen_hi[1][gen_cnt] = it.ay < it.by ? it.by : it.ay;
            gen_lo[2][gen_cnt] = it.az < it.bz ? it.az : it.bz;
            gen_hi[2][gen_cnt] = it.az < it.bz ? it.bz : it.az;
            gen_cnt++;
        end
        pend_q = {pend_q, it};
    endtask

    task automatic add_box(int gap);
        longint c[3], h[3];
        for (int k = 0; k < 3; k++) begin
            c[k] = rnd_coord(64);
            h[k] = longint'($urandom_range(0, 8 * 65536));
        end
        if ($urandom_range(0, 9) == 0) h[$urandom_range(0, 2)] = 0;
        add_item(rbnh_pkg::REQ_APPEND, c[0] - h[0], c[1] - h[1], c[2] - h[2],
                 c[0] + h[0], c[1] + h[1], c[2] + h[2], 0, gap);
    endtask

    task automatic add_cast(int gap);
        longint o[3], d[3], tgt[3], m, md;
        int k, z;
        k = gen_cnt > 0 ? $urandom_range(0, gen_cnt - 1) : -1;
        for (int j = 0; j < 3; j++) begin
            tgt[j] = k < 0 ? rnd_coord(64) : (gen_lo[j][k] + gen_hi[j][k]) / 2;
            o[j] = $urandom_range(0, 9) == 0 ? tgt[j] : rnd_coord(100);
        end
        if ($urandom_range(0, 3) == 0) o[1] = longint'($urandom_range(0, 50 * 65536));
        m = 1;
        for (int j = 0; j < 3; j++) begin
            d[j] = tgt[j] - o[j];
            if ((d[j] < 0 ? -d[j] : d[j]) > m) m = d[j] < 0 ? -d[j] : d[j];
        end
        for (int j = 0; j < 3; j++)
            d[j] = d[j] * 65536 / m + longint'($urandom_range(0, 1024)) - 512;
        if ($urandom_range(0, 4) == 0) begin
            z = $urandom_range(0, 2);
            d[z] = 0;
            if (k >= 0 && $urandom_range(0, 1)) o[z] = gen_hi[z][k];
        end
        case ($urandom_range(0, 6))
            0: md = $urandom_range(0, 32'h7fff_ffff);
            1: md = $urandom_range(0, 100 * 65536);
            default: md = 32'h7fff_ffff;
        endcase
        add_item(rbnh_pkg::REQ_CAST, o[0], o[1], o[2], d[0], d[1], d[2], md, gap);
    endtask

    task automatic add_raw(int gap);
        rbnh_pkg::t_req rq;
        rq = rbnh_pkg::t_req'($urandom_range(0, 3));
        if (rq == rbnh_pkg::REQ_APPEND && gen_cnt >= 8) rq = rbnh_pkg::REQ_CAST;
        add_item(rq, $signed($urandom), $signed($urandom), $signed($urandom),
                 $signed($urandom), $signed($urandom), $signed($urandom),
                 $urandom, gap);
    endtask

    function automatic int pick_gap(bit quiet);
        if (quiet || $urandom_range(0, 9) < 7) return 0;
        return $urandom_range(1, 17);
    endfunction

    localparam longint UNIT = 65536;
    localparam longint IMIN = -64'sd2147483648;
    localparam longint IMAX = 64'sd2147483647;

    initial begin
        int r, n_rand;
        bit quiet;
        // directed
        add_item(rbnh_pkg::REQ_CAST, 0, UNIT, 0, UNIT, -UNIT, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_APPEND, IMAX, IMAX, IMAX, IMIN, IMIN, IMIN, 0, 0);
        add_item(rbnh_pkg::REQ_CAST, 0, 0, 0, UNIT, 0, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, IMIN, IMAX, IMIN, IMIN, IMIN, IMIN, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, IMAX, IMIN, IMAX, IMAX, IMAX, IMAX, 0, 0);
        add_item(rbnh_pkg::REQ_CLEAR, IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, IMAX, 0);
        add_item(rbnh_pkg::REQ_NOP, -1, -1, -1, -1, -1, -1, IMAX, 0);
        add_item(rbnh_pkg::REQ_APPEND, 2 * UNIT, -UNIT, -UNIT, 4 * UNIT, UNIT, UNIT, 0, 0);
        add_item(rbnh_pkg::REQ_APPEND, -4 * UNIT, UNIT, UNIT, -2 * UNIT, -UNIT, -UNIT, 0, 0);
        add_item(rbnh_pkg::REQ_APPEND, 2 * UNIT, -UNIT, -UNIT, 4 * UNIT, UNIT, UNIT, 0, 0);
        add_item(rbnh_pkg::REQ_CAST, 0, 0, 0, UNIT, 0, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 0, 0, 0, -UNIT, 0, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 3 * UNIT, 5 * UNIT, 0, 0, -UNIT, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 3 * UNIT, -5 * UNIT, 0, 0, UNIT, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 3 * UNIT, 0, 5 * UNIT, 0, 0, -UNIT, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 3 * UNIT, 0, -5 * UNIT, 0, 0, UNIT, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 0, UNIT, 0, UNIT, 0, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 0, 0, 0, UNIT, 0, 0, UNIT, 0);
        add_item(rbnh_pkg::REQ_CAST, 3 * UNIT, 0, 0, 0, 0, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, -2 * UNIT, 0, 0, 0, 0, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 9 * UNIT, 10 * UNIT, 9 * UNIT, 0, -7, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 9 * UNIT, 10 * UNIT, 9 * UNIT, 0, -6, 0, IMAX, 0);
        add_item(rbnh_pkg::REQ_CAST, 9 * UNIT, 10 * UNIT, 9 * UNIT, 0, -2 * UNIT, 0,
                 2 * UNIT, 0);
        add_item(rbnh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        pend_q[$].drain = 1;
        // random
        n_rand = 370;
        for (int i = 0; i < n_rand; i++) begin
            quiet = i > n_rand - 80;
            if (i == n_rand - 120) begin
                add_item(rbnh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, pick_gap(0));
                pend_q[$].drain = 1;
                for (int j = 0; j < rbnh_pkg::MAX_BOXES; j++) add_box(pick_gap(0));
                add_box(0);
                add_cast(0);
                add_item(rbnh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
            end
            r = $urandom_range(0, 99);
            if (i % 100 == 50) pend_q[$].drain = 1;
            if (r < 5) add_item(rbnh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, pick_gap(quiet));
            else if (r < 35 && gen_cnt < 8) add_box(pick_gap(quiet));
            else if (r < 38) add_item(rbnh_pkg::REQ_NOP, $signed($urandom), 0, 0, 0, 0, 0,
                                      $urandom, pick_gap(quiet));
            else if (r < 45) add_raw(pick_gap(quiet));
            else add_cast(pick_gap(quiet));
        end
        gen_done = 1;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!(gen_done && pend_q.size() == 0 && !start && hit_q.size() == 0))
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
